### hw/rtl/ptpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpn_pkg: shared types and constants for the planar tile to packed nibble
// raster core.
// ----------------------------------------------------------------------------
package ptpn_pkg;

  localparam int unsigned IMAGE_BYTES_DEF = 8192;

  localparam int unsigned PLANE_W   = 8;
  localparam int unsigned PIXELS_W  = 32;
  localparam int unsigned TILE_W    = 8;   // width/height/column/row counters
  localparam int unsigned ROW_W     = 3;   // row inside a tile
  localparam int unsigned DIST_W    = 13;  // rows from bottom, modulo 2^13
  localparam int unsigned STRIDE_W  = 10;  // width_tiles * 4
  localparam int unsigned PROD_W    = DIST_W + STRIDE_W;
  localparam int unsigned ADDR_W    = 13;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [TILE_W-1:0] WIDTH_RESET  = 8'd16;
  localparam logic [TILE_W-1:0] HEIGHT_RESET = 8'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TILES    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TILES   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_PLANE_MODE = 8'd2;

  // one classified tile row, handed from the front to the back
  typedef struct packed {
    logic [PIXELS_W-1:0] pixels;
    logic [DIST_W-1:0]   lines_below;  // height*8 - 1 - y, low bits
    logic [STRIDE_W-1:0] stride;       // bytes per raster line
    logic [STRIDE_W-1:0] col_ofs;      // tile_column * 4
    logic                beyond;       // counters outside the image
    logic                last;
  } row_entry_t;

  // planar to chunky: pixel x takes bit 7-x of each plane
  function automatic logic [PIXELS_W-1:0] pack_row(
    input logic [PLANE_W-1:0] p0,
    input logic [PLANE_W-1:0] p1,
    input logic [PLANE_W-1:0] p2,
    input logic [PLANE_W-1:0] p3,
    input logic               two_plane
  );
    logic [PIXELS_W-1:0] res;
    logic [3:0]          nib;
    res = '0;
    for (int x = 0; x < 8; x++) begin
      nib = {p3[7-x] & ~two_plane, p2[7-x] & ~two_plane, p1[7-x], p0[7-x]};
      // byte x/2, even pixel in the high nibble
      res[8*(x/2) + 4*(1 - (x%2)) +: 4] = nib;
    end
    return res;
  endfunction

endpackage

### hw/rtl/ptpn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpn_front: config registers, position counters and bit shuffle
// Takes tile row beats, packs the pixels and tags each with its raster
// position terms before handing it to the queue.
// ----------------------------------------------------------------------------
module ptpn_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ptpn_pkg::PLANE_W-1:0]        plane0_bits_i,
  input  logic [ptpn_pkg::PLANE_W-1:0]        plane1_bits_i,
  input  logic [ptpn_pkg::PLANE_W-1:0]        plane2_bits_i,
  input  logic [ptpn_pkg::PLANE_W-1:0]        plane3_bits_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ptpn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ptpn_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  output logic                                push_o,
  output ptpn_pkg::row_entry_t                push_entry_o,
  input  logic                                push_ready_i
);

  localparam logic [ptpn_pkg::ROW_W-1:0] ROW_LAST = '1;

  logic [ptpn_pkg::TILE_W-1:0] width_q, height_q;
  logic                        two_plane_q;
  logic [ptpn_pkg::ROW_W-1:0]  row_q, row_d;
  logic [ptpn_pkg::TILE_W-1:0] col_q, col_d;
  logic [ptpn_pkg::TILE_W-1:0] trow_q, trow_d;

  logic                        accept;
  logic                        col_end, row_end;
  logic [ptpn_pkg::TILE_W+ptpn_pkg::ROW_W-1:0] y_pos, h_lines;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = push_ready_i;
  assign accept      = in_valid_i & push_ready_i;
  assign push_o      = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ptpn_pkg::WIDTH_RESET;
      height_q    <= ptpn_pkg::HEIGHT_RESET;
      two_plane_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ptpn_pkg::REG_WIDTH_TILES:    width_q     <= cfg_data_i[ptpn_pkg::TILE_W-1:0];
        ptpn_pkg::REG_HEIGHT_TILES:   height_q    <= cfg_data_i[ptpn_pkg::TILE_W-1:0];
        ptpn_pkg::REG_TWO_PLANE_MODE: two_plane_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // wrap tests compare with >= so a zero size still returns to zero
  assign col_end = ({1'b0, col_q} + 9'd1) >= {1'b0, width_q};
  assign row_end = ({1'b0, trow_q} + 9'd1) >= {1'b0, height_q};

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    trow_d = trow_q;
    if (row_q == ROW_LAST) begin
      row_d = '0;
      if (col_end) begin
        col_d  = '0;
        trow_d = row_end ? '0 : trow_q + 8'd1;
      end else begin
        col_d = col_q + 8'd1;
      end
    end else begin
      row_d = row_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      trow_q <= '0;
    end else if (accept) begin
      row_q  <= row_d;
      col_q  <= col_d;
      trow_q <= trow_d;
    end
  end

  assign y_pos   = {trow_q, row_q};
  assign h_lines = {height_q, 3'b000};

  always_comb begin
    push_entry_o.pixels      = ptpn_pkg::pack_row(plane0_bits_i, plane1_bits_i,
                                                  plane2_bits_i, plane3_bits_i,
                                                  two_plane_q);
    // goes negative only when the row counter is beyond the image
    push_entry_o.lines_below = {2'b00, h_lines} - 13'd1 - {2'b00, y_pos};
    push_entry_o.stride      = {width_q, 2'b00};
    push_entry_o.col_ofs     = {col_q, 2'b00};
    push_entry_o.beyond      = (col_q >= width_q) | (trow_q >= height_q);
    push_entry_o.last        = (row_q == ROW_LAST) & col_end & row_end;
  end

endmodule

### hw/rtl/ptpn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpn_queue: two-entry queue between front and back
// Full rate in both directions; decouples front stalls from back stalls.
// ----------------------------------------------------------------------------
module ptpn_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ptpn_pkg::row_entry_t push_entry_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output ptpn_pkg::row_entry_t pop_entry_o,
  input  logic                 pop_i
);

  ptpn_pkg::row_entry_t slot_q [2];
  logic                 wr_q, rd_q;
  logic [1:0]           count_q;
  logic                 do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_entry_o  = slot_q[rd_q];
  assign do_pop       = pop_i & pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

endmodule

### hw/rtl/ptpn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpn_back: raster address pipeline and output register
// Stage one multiplies line distance by stride; stage two adds the column
// offset, checks the buffer bound and holds the result beat.
// ----------------------------------------------------------------------------
module ptpn_back #(
  parameter int unsigned IMAGE_BYTES = ptpn_pkg::IMAGE_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  input  ptpn_pkg::row_entry_t                pop_entry_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ptpn_pkg::ADDR_W-1:0]         byte_address_o,
  output logic [ptpn_pkg::PIXELS_W-1:0]       packed_pixels_o,
  output logic                                out_of_range_o,
  output logic                                last_of_image_o
);

  localparam int unsigned CMP_W = ptpn_pkg::PROD_W + 1;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(IMAGE_BYTES);

  // stage one
  logic                           s1_valid_q;
  logic [ptpn_pkg::PROD_W-1:0]    s1_prod_q;
  logic [ptpn_pkg::STRIDE_W-1:0]  s1_col_q;
  logic [ptpn_pkg::PIXELS_W-1:0]  s1_pixels_q;
  logic                           s1_beyond_q, s1_last_q;
  logic                           s1_ready, s1_load;

  // stage two (output register)
  logic                           s2_valid_q;
  logic [ptpn_pkg::ADDR_W-1:0]    s2_addr_q;
  logic [ptpn_pkg::PIXELS_W-1:0]  s2_pixels_q;
  logic                           s2_oor_q, s2_last_q;
  logic                           s2_ready, s2_load;
  logic [ptpn_pkg::PROD_W-1:0]    addr_full;
  logic                           oor;

  assign s2_ready = ~s2_valid_q | out_ready_i;
  assign s1_ready = ~s1_valid_q | s2_ready;
  assign pop_o    = s1_ready;
  assign s1_load  = s1_ready & pop_valid_i;
  assign s2_load  = s2_ready & s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= pop_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_prod_q   <= ptpn_pkg::PROD_W'(pop_entry_i.lines_below) *
                     ptpn_pkg::PROD_W'(pop_entry_i.stride);
      s1_col_q    <= pop_entry_i.col_ofs;
      s1_pixels_q <= pop_entry_i.pixels;
      s1_beyond_q <= pop_entry_i.beyond;
      s1_last_q   <= pop_entry_i.last;
    end
  end

  // exact when inside the image; only the low bits matter otherwise
  assign addr_full = s1_prod_q + ptpn_pkg::PROD_W'(s1_col_q);
  assign oor       = s1_beyond_q | (({1'b0, addr_full} + CMP_W'(3)) >= LIMIT);

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_addr_q   <= addr_full[ptpn_pkg::ADDR_W-1:0];
      s2_pixels_q <= s1_pixels_q;
      s2_oor_q    <= oor;
      s2_last_q   <= s1_last_q;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign byte_address_o  = s2_addr_q;
  assign packed_pixels_o = s2_pixels_q;
  assign out_of_range_o  = s2_oor_q;
  assign last_of_image_o = s2_last_q;

endmodule

### hw/rtl/planar_tile_to_packed_nibble_raster_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_tile_to_packed_nibble_raster_core: 4bpp planar tile rows to packed
// nibble bytes with bottom-up raster addresses.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one beat is one 8-pixel tile row
//    as four bitplane bytes. Rows of a tile top to bottom, tiles left to
//    right, tile rows top to bottom.
//  - Output channel (out_valid_o/out_ready_i): one beat per input beat with
//    the 32-bit packed row, the byte address of its first byte in a
//    bottom-up raster, an out-of-range flag and an end-of-image flag.
//  - Config channel (cfg_valid_i/cfg_ready_o): index 0 width in tiles,
//    1 height in tiles, 2 two-plane mode. Always ready; write only while
//    the block is drained. Other indexes are ignored.
//  - Path: a result passes the queue slot, the multiply stage and the
//    output register, in that order, after its input beat is taken.
//  - Throughput: one beat per cycle while the receiver is ready, set by the
//    combinational front and the two-stage address pipeline in the back.
//  - Receiver stall: the two-entry queue and pipeline stages fill; input
//    ready drops only once the queue is full. Nothing is dropped.
//  - Reset: size registers to 16x16 tiles, four-plane mode, position
//    counters to the top-left tile, all stages empty.
// ----------------------------------------------------------------------------
module planar_tile_to_packed_nibble_raster_core #(
  parameter int unsigned IMAGE_BYTES = ptpn_pkg::IMAGE_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ptpn_pkg::PLANE_W-1:0]        plane0_bits_i,
  input  logic [ptpn_pkg::PLANE_W-1:0]        plane1_bits_i,
  input  logic [ptpn_pkg::PLANE_W-1:0]        plane2_bits_i,
  input  logic [ptpn_pkg::PLANE_W-1:0]        plane3_bits_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ptpn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ptpn_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ptpn_pkg::ADDR_W-1:0]         byte_address_o,
  output logic [ptpn_pkg::PIXELS_W-1:0]       packed_pixels_o,
  output logic                                out_of_range_o,
  output logic                                last_of_image_o
);

  // front -> queue
  logic                 push;
  logic                 push_ready;
  ptpn_pkg::row_entry_t push_entry;

  // queue -> back
  logic                 pop_valid;
  logic                 pop;
  ptpn_pkg::row_entry_t pop_entry;

  // Front: owns the config registers and position counters, so each row is
  // tagged with its position at accept time.
  ptpn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .plane0_bits_i(plane0_bits_i),
    .plane1_bits_i(plane1_bits_i),
    .plane2_bits_i(plane2_bits_i),
    .plane3_bits_i(plane3_bits_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  ptpn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_entry_o (pop_entry),
    .pop_i       (pop)
  );

  // Back: address multiply, bound check and output register.
  ptpn_back #(
    .IMAGE_BYTES(IMAGE_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_entry_i    (pop_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_address_o (byte_address_o),
    .packed_pixels_o(packed_pixels_o),
    .out_of_range_o (out_of_range_o),
    .last_of_image_o(last_of_image_o)
  );

endmodule
